// ===== rtl/idle_timeout_frame_receiver_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Idle timeout frame receiver assertion macros
// Concurrent assertion shorthands for the frame receiver, clocked on aclk and
// disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef IDLE_TIMEOUT_FRAME_RECEIVER_UNIT_ASSERT_SVH
`define IDLE_TIMEOUT_FRAME_RECEIVER_UNIT_ASSERT_SVH

// Checks that the consequent holds in the same cycle as the antecedent.
`define ITFR_ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Checks that the consequent holds in the cycle after the antecedent.
`define ITFR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/itfr_pkg.sv =====
// ----------------------------------------------------------------------------
// Idle timeout frame receiver package
// Shared types and constants of the frame receiver.
// ----------------------------------------------------------------------------
package itfr_pkg;

    localparam int TIMER_W  = 16;
    localparam int BYTE_W   = 8;
    localparam int LEN_W    = 6;
    localparam int OPCODE_W = 2;
    localparam int CFG_IDX_W = 1;

    localparam logic [TIMER_W-1:0] TIMER_MAX         = '1;
    localparam logic [TIMER_W-1:0] START_TIMEOUT_RST = 16'd1000;
    localparam logic [TIMER_W-1:0] GAP_TIMEOUT_RST   = 16'd20;

    typedef enum logic [OPCODE_W-1:0] {
        OP_TICK  = 2'd0,
        OP_BYTE  = 2'd1,
        OP_REARM = 2'd2
    } opcode_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_START_TIMEOUT = 1'b0,
        CFG_GAP_TIMEOUT   = 1'b1
    } cfg_index_t;

    typedef enum logic [1:0] {
        PH_WAIT  = 2'd0,
        PH_RECV  = 2'd1,
        PH_DONE  = 2'd2,
        PH_DRAIN = 2'd3
    } phase_t;

endpackage

// ===== rtl/itfr_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single port write, single port read RAM
// One write and one read per cycle; the read data is registered and holds
// its value while no read is issued.
// ----------------------------------------------------------------------------
module itfr_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 32
) (
    input  logic                                      aclk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ===== rtl/idle_timeout_frame_receiver_unit.sv =====
// ----------------------------------------------------------------------------
// Idle timeout frame receiver
// A tick that ends the start timeout shows its result in the next cycle.
// Throughput: one input beat per cycle outside a frame drain and while no result beat is stalled on m_ready.
// A drain reads the frame RAM and gives one result beat per cycle while m_ready is high.
// Reset: synchronous, active low; waits for a first byte with default timeouts.
// ----------------------------------------------------------------------------
`include "idle_timeout_frame_receiver_unit_assert.svh"

module idle_timeout_frame_receiver_unit
    import itfr_pkg::*;
#(
    parameter int BUF_LEN = 32
) (
    input  logic                 aclk,
    input  logic                 aresetn,

    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [TIMER_W-1:0]   cfg_data,

    input  logic                 s_valid,
    output logic                 s_ready,
    input  logic [OPCODE_W-1:0]  s_opcode,
    input  logic [BYTE_W-1:0]    s_rx_byte,

    output logic                 m_valid,
    input  logic                 m_ready,
    output logic                 m_status,
    output logic [BYTE_W-1:0]    m_frame_byte,
    output logic [LEN_W-1:0]     m_frame_length,
    output logic                 m_last
);

    localparam int CW = $clog2(BUF_LEN + 1);
    localparam int AW = (BUF_LEN > 1) ? $clog2(BUF_LEN) : 1;

    phase_t             phase_reg, phase_next;
    logic [TIMER_W-1:0] start_timeout_reg, gap_timeout_reg;
    logic [TIMER_W-1:0] elapsed_reg, elapsed_next;
    logic [CW-1:0]      count_reg, count_next;
    logic [CW-1:0]      rd_idx_reg, rd_idx_next;
    logic               rd_pend_reg, rd_pend_next;
    logic               pend_last_reg, pend_last_next;

    logic               m_valid_reg, m_valid_next;
    logic               m_status_reg, m_status_next;
    logic [BYTE_W-1:0]  m_frame_byte_reg, m_frame_byte_next;
    logic [LEN_W-1:0]   m_frame_length_reg, m_frame_length_next;
    logic               m_last_reg, m_last_next;

    logic               in_acc, is_tick, is_byte, is_rearm, armed;
    logic [TIMER_W-1:0] elapsed_inc;
    logic               timeout_fire, drain_start, load_now, rd_en, drain_end;
    logic [CW-1:0]      wr_idx;
    logic               wr_en;
    logic [BYTE_W-1:0]  rd_data;

    assign in_acc   = s_valid && s_ready;
    assign is_tick  = s_opcode == OP_TICK;
    assign is_byte  = s_opcode == OP_BYTE;
    assign is_rearm = s_opcode == OP_REARM;
    assign armed    = (phase_reg == PH_WAIT) || (phase_reg == PH_RECV);

    assign elapsed_inc  = (elapsed_reg == TIMER_MAX) ? elapsed_reg : elapsed_reg + 1'b1;
    assign timeout_fire = in_acc && is_tick && (phase_reg == PH_WAIT)
                          && (elapsed_inc >= start_timeout_reg);
    assign drain_start  = in_acc && is_tick && (phase_reg == PH_RECV)
                          && (elapsed_inc >= gap_timeout_reg);

    assign load_now  = rd_pend_reg && (!m_valid_reg || m_ready);
    assign rd_en     = (phase_reg == PH_DRAIN) && (rd_idx_reg != count_reg)
                       && (!rd_pend_reg || load_now);
    assign drain_end = (phase_reg == PH_DRAIN) && (rd_idx_reg == count_reg)
                       && (!rd_pend_reg || load_now);

    assign wr_idx = (phase_reg == PH_WAIT) ? '0 : count_reg;
    assign wr_en  = in_acc && is_byte && armed && (wr_idx < CW'(BUF_LEN));

    assign s_ready   = (phase_reg != PH_DRAIN) && (!m_valid_reg || m_ready);
    assign cfg_ready = 1'b1;

    // Writes happen only while waiting for or receiving a frame and reads only
    // while draining, so the same entry is never written and read in overlapping cycles.
    itfr_ram #(
        .WIDTH(BYTE_W),
        .DEPTH(BUF_LEN)
    ) u_frame_ram (
        .aclk (aclk),
        .we   (wr_en),
        .waddr(wr_idx[AW-1:0]),
        .wdata(s_rx_byte),
        .re   (rd_en),
        .raddr(rd_idx_reg[AW-1:0]),
        .rdata(rd_data)
    );

    always_comb begin
        phase_next = phase_reg;
        unique case (phase_reg)
            PH_WAIT: begin
                if (in_acc && is_byte) begin
                    phase_next = PH_RECV;
                end else if (timeout_fire) begin
                    phase_next = PH_DONE;
                end
            end
            PH_RECV: begin
                if (in_acc && is_rearm) begin
                    phase_next = PH_WAIT;
                end else if (drain_start) begin
                    phase_next = PH_DRAIN;
                end
            end
            PH_DONE: begin
                if (in_acc && is_rearm) begin
                    phase_next = PH_WAIT;
                end
            end
            PH_DRAIN: begin
                if (drain_end) begin
                    phase_next = PH_DONE;
                end
            end
        endcase
    end

    always_comb begin
        elapsed_next        = elapsed_reg;
        count_next          = count_reg;
        rd_idx_next         = rd_idx_reg;
        rd_pend_next        = rd_pend_reg;
        pend_last_next      = pend_last_reg;
        m_valid_next        = m_valid_reg;
        m_status_next       = m_status_reg;
        m_frame_byte_next   = m_frame_byte_reg;
        m_frame_length_next = m_frame_length_reg;
        m_last_next         = m_last_reg;

        if (in_acc && is_rearm) begin
            elapsed_next = '0;
            count_next   = '0;
        end else if (in_acc && is_byte && armed) begin
            elapsed_next = '0;
            count_next   = wr_en ? CW'(wr_idx + 1'b1) : wr_idx;
        end else if (in_acc && is_tick && armed) begin
            elapsed_next = elapsed_inc;
        end

        if (drain_start) begin
            rd_idx_next = '0;
        end else if (rd_en) begin
            rd_idx_next = CW'(rd_idx_reg + 1'b1);
        end

        if (rd_en) begin
            rd_pend_next   = 1'b1;
            pend_last_next = (rd_idx_reg + CW'(1)) == count_reg;
        end else if (load_now) begin
            rd_pend_next = 1'b0;
        end

        if (m_ready) begin
            m_valid_next = 1'b0;
        end
        if (timeout_fire) begin
            m_valid_next        = 1'b1;
            m_status_next       = 1'b1;
            m_frame_byte_next   = '0;
            m_frame_length_next = '0;
            m_last_next         = 1'b1;
        end else if (load_now) begin
            m_valid_next        = 1'b1;
            m_status_next       = 1'b0;
            m_frame_byte_next   = rd_data;
            m_frame_length_next = LEN_W'(count_reg);
            m_last_next         = pend_last_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg         <= PH_WAIT;
            start_timeout_reg <= START_TIMEOUT_RST;
            gap_timeout_reg   <= GAP_TIMEOUT_RST;
            elapsed_reg       <= '0;
            count_reg         <= '0;
            rd_idx_reg        <= '0;
            rd_pend_reg       <= 1'b0;
            m_valid_reg       <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            elapsed_reg <= elapsed_next;
            count_reg   <= count_next;
            rd_idx_reg  <= rd_idx_next;
            rd_pend_reg <= rd_pend_next;
            m_valid_reg <= m_valid_next;
            if (cfg_valid && cfg_ready) begin
                unique case (cfg_index)
                    CFG_START_TIMEOUT: start_timeout_reg <= cfg_data;
                    CFG_GAP_TIMEOUT:   gap_timeout_reg   <= cfg_data;
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        pend_last_reg      <= pend_last_next;
        m_status_reg       <= m_status_next;
        m_frame_byte_reg   <= m_frame_byte_next;
        m_frame_length_reg <= m_frame_length_next;
        m_last_reg         <= m_last_next;
    end

    assign m_valid        = m_valid_reg;
    assign m_status       = m_status_reg;
    assign m_frame_byte   = m_frame_byte_reg;
    assign m_frame_length = m_frame_length_reg;
    assign m_last         = m_last_reg;

    `ITFR_ASSERT_SAME(a_no_input_in_drain, phase_reg == PH_DRAIN, !s_ready, "input taken during drain")
    `ITFR_ASSERT_SAME(a_read_in_range, rd_en, rd_idx_reg < count_reg, "drain read past frame")
    `ITFR_ASSERT_SAME(a_count_bound, 1'b1, count_reg <= CW'(BUF_LEN), "stored count over buffer")
    `ITFR_ASSERT_NEXT(a_timeout_result, timeout_fire, m_valid && m_status && m_last, "timeout beat missing")

endmodule
